FILE: hdl/depq_pkg.sv
// shared types and constants for the double-ended priority queue
// holds the transfer structs, operation and status codes, and the cell link struct
// no dependencies
package depq_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;

    // operation codes
    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_GET_MIN = 2'd1;
    localparam logic [1:0] FUNC_GET_MAX = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // request transfer
    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // response transfer
    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
    } rsp_t;

    // command broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     pop_min;
        logic                     pop_max;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     lt;
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

endpackage

FILE: hdl/depq_cell.sv
// one cell of the sorted chain: holds one entry and its valid bit
// shifts right on insert, left on get-min, drops its entry on get-max when it is the top; depends on depq_pkg
module depq_cell
    import depq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    input  cell_link_t               left,
    input  cell_link_t               right,
    output cell_link_t               link,
    output logic                     top,
    output logic signed [DATA_W-1:0] top_value
);

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     lt;

    // entry is held and smaller than the broadcast value
    assign lt = valid_reg && ($signed(value_reg) < $signed(cmd.value));

    assign link.valid = valid_reg;
    assign link.lt    = lt;
    assign link.value = value_reg;

    // highest valid entry of the chain
    assign top       = valid_reg && !right.valid;
    assign top_value = top ? value_reg : '0;

    // next entry and valid bit
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.ins)
        begin
            valid_next = valid_reg | left.valid;
            if (!lt)
            begin
                value_next = left.lt ? cmd.value : left.value;
            end
        end
        else if (cmd.pop_min)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (cmd.pop_max)
        begin
            valid_next = valid_reg & right.valid;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

FILE: hdl/double_ended_priority_queue.sv
// double-ended priority queue built as a chain of sorted cells
// the broadcast compare and shift updates every cell at the accepting edge
// and the result is loaded into the output register at that same edge
// throughput one transfer per cycle; the input stalls only while a result waits under rsp_stall
// reset clears all cell valid bits and the output valid flag; entries need no clearing
// depends on depq_pkg and depq_cell
module double_ended_priority_queue
    import depq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cell_cmd_t                cmd;
    cell_link_t               links     [CAPACITY];
    cell_link_t               left_in   [CAPACITY];
    cell_link_t               right_in  [CAPACITY];
    logic [CAPACITY-1:0]      top_vec;
    logic signed [DATA_W-1:0] top_values [CAPACITY];
    logic signed [DATA_W-1:0] max_value;
    logic                     accept;
    logic                     empty;
    logic                     full;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    // input transfer handshake
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign empty     = !links[0].valid;
    assign full      = links[CAPACITY-1].valid;

    // command broadcast
    always_comb
    begin
        cmd.ins     = accept && (req.func == FUNC_INSERT) && !full;
        cmd.pop_min = accept && (req.func == FUNC_GET_MIN) && !empty;
        cmd.pop_max = accept && (req.func == FUNC_GET_MAX) && !empty;
        cmd.value   = req.value;
    end

    // cell chain
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                assign left_in[i] = '{valid: 1'b1, lt: 1'b1, value: '0};
            end
            else
            begin : g_mid_l
                assign left_in[i] = links[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_in[i] = '{valid: 1'b0, lt: 1'b0, value: '0};
            end
            else
            begin : g_mid_r
                assign right_in[i] = links[i+1];
            end
            depq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .left      (left_in[i]),
                .right     (right_in[i]),
                .link      (links[i]),
                .top       (top_vec[i]),
                .top_value (top_values[i])
            );
        end
    endgenerate

    // largest entry: only the top cell drives nonzero
    always_comb
    begin
        max_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            max_value = max_value | top_values[k];
        end
    end

    // result of the accepted transfer
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (accept)
        begin
            unique case (req.func) inside
                FUNC_INSERT:
                begin
                    if (full)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next       = '{value_out: '0, status: ST_FULL};
                    end
                end
                FUNC_GET_MIN, FUNC_GET_MAX:
                begin
                    rsp_valid_next = 1'b1;
                    if (empty)
                    begin
                        rsp_next = '{value_out: '0, status: ST_EMPTY};
                    end
                    else if (req.func == FUNC_GET_MIN)
                    begin
                        rsp_next = '{value_out: links[0].value, status: ST_OK};
                    end
                    else
                    begin
                        rsp_next = '{value_out: max_value, status: ST_OK};
                    end
                end
                default:
                begin
                    rsp_next = rsp_reg;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // at most one cell marks the top of the sorted run
    a_single_top: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(top_vec))
        else $error("more than one top cell");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> (rsp.value_out == '0))
        else $error("error result with nonzero value");

    // a get on an empty queue reports empty
    a_empty_get: assert property (@(posedge clk) disable iff (!rst_n)
        accept && empty && ((req.func == FUNC_GET_MIN) || (req.func == FUNC_GET_MAX))
        |=> rsp_valid && (rsp.status == ST_EMPTY))
        else $error("get on empty queue not flagged");

    // an accepted insert leaves the queue nonempty
    a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> links[0].valid)
        else $error("insert lost");

endmodule

FILE: bench/tb_double_ended_priority_queue.sv
// testbench for double_ended_priority_queue: random and directed insert, get-min and get-max
// traffic with a sorted-queue predictor, a scoreboard and random idling on both channels
// depends on depq_pkg and the double_ended_priority_queue rtl
module tb_double_ended_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import depq_pkg::*;

    // operation code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int OP_TARGET      = 1650;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int REPORT_MAX     = 10;

    typedef struct {
        req_t        item;
        int unsigned gap;
        bit          drain_first;
    } stim_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // stimulus and prediction state
    stim_t                    pending_req[$];
    stim_t                    staged_item;
    bit                       staged;
    logic signed [DATA_W-1:0] model_entries[$];
    rsp_t                     awaited_rsp[$];
    int                       ops_queued;
    bit                       req_taken;

    // statistics and error tracking
    int accepted_items;
    int rsp_count;
    int empty_hits;
    int full_hits;
    int ignored_hits;
    int max_depth;
    int mismatches;
    int idle_cycles;

    // receiver idling state
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_left;
    int unsigned calm_left;

    // driver scratch
    logic valid_next;
    req_t req_next;
    logic stall_next;

    double_ended_priority_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    // remove and return the largest predicted entry
    function automatic logic signed [DATA_W-1:0] take_largest();
        logic signed [DATA_W-1:0] v;
        v = model_entries[model_entries.size() - 1];
        model_entries.delete(model_entries.size() - 1);
        return v;
    endfunction

    // sorted queue predictor: one accepted request, zero or one expected result
    function automatic void sorted_model_step(input req_t r);
        rsp_t                     res;
        int                       pos;
        logic signed [DATA_W-1:0] v;
        res = '0;
        v   = r.value;
        case (r.func) inside
            FUNC_INSERT:
            begin
                if (model_entries.size() >= CAPACITY)
                begin
                    res.status = ST_FULL;
                    awaited_rsp.push_back(res);
                    full_hits++;
                end
                else
                begin
                    // new value goes in front of any equal entries
                    pos = 0;
                    while (pos < model_entries.size() && model_entries[pos] < v)
                        pos++;
                    model_entries.insert(pos, v);
                    if (model_entries.size() > max_depth)
                        max_depth = model_entries.size();
                end
            end
            FUNC_GET_MIN, FUNC_GET_MAX:
            begin
                if (model_entries.size() == 0)
                begin
                    res.status = ST_EMPTY;
                    empty_hits++;
                end
                else
                begin
                    res.status    = ST_OK;
                    res.value_out = (r.func == FUNC_GET_MIN) ? model_entries.pop_front()
                                                            : take_largest();
                end
                awaited_rsp.push_back(res);
            end
            default:
                ignored_hits++;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 8)
            return $signed($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 3))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            default: return -32'sd1;
        endcase
    endfunction

    // idle cycles ahead of an item: mostly none, a few short, rarely long
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void add_item(input logic [1:0] func,
                                     input logic signed [DATA_W-1:0] value,
                                     input int unsigned gap, input bit drain_first);
        stim_t s;
        s.item.func   = func;
        s.item.value  = value;
        s.gap         = gap;
        s.drain_first = drain_first;
        pending_req.push_back(s);
        if (func != FUNC_UNUSED)
            ops_queued++;
    endfunction

    function automatic logic [1:0] pick_get();
        return $urandom_range(0, 1) ? FUNC_GET_MIN : FUNC_GET_MAX;
    endfunction

    task automatic note_failure(input string what, input rsp_t want, input rsp_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s: expected value %0d status %0d, got value %0d status %0d",
                     what, want.value_out, want.status, got.value_out, got.status);
    endtask

    // request driver: holds a payload until its transfer, then stages the next one
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            valid_next = req_valid;
            req_next   = req;
            if (req_valid && req_taken)
                valid_next = 1'b0;
            if (!valid_next)
            begin
                if (!staged && pending_req.size() > 0)
                begin
                    staged_item = pending_req.pop_front();
                    staged      = 1'b1;
                end
                if (staged)
                begin
                    if (staged_item.gap > 0)
                        staged_item.gap--;
                    else if (!staged_item.drain_first || awaited_rsp.size() == 0)
                    begin
                        valid_next = 1'b1;
                        req_next   = staged_item.item;
                        staged     = 1'b0;
                    end
                end
            end
            req_valid <= valid_next;
            req       <= req_next;
        end
    end

    // response side stall: one long hold-off, random short and long stalls, quiet stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_next = 1'b0;
            if (!hold_done && accepted_items >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (calm_left > 0)
                calm_left--;
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1:    calm_left  = $urandom_range(20, 100);
                    2:       stall_left = $urandom_range(10, 40);
                    3, 4, 5: stall_left = $urandom_range(1, 3);
                    default: ;
                endcase
                stall_next = (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
            rsp_stall <= stall_next;
        end
    end

    // monitor: check results, feed accepted requests to the predictor, watchdog
    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
            req_taken = 1'b0;
        else
        begin
            req_taken = req_valid && !req_stall;
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (awaited_rsp.size() == 0)
                    note_failure("unexpected result", '0, rsp);
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.value_out !== want.value_out || rsp.status !== want.status)
                        note_failure("result mismatch", want, rsp);
                end
            end
            if (req_taken)
            begin
                sorted_model_step(req);
                accepted_items++;
            end
            if (req_taken || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                             idle_cycles, awaited_rsp.size());
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int          phase_no;
        int          kind;
        int          len;
        int          r;
        bit          quiet;
        bit          drain_first;
        logic [1:0]  func;

        // directed: empty gets, extremes, duplicates, ignored code, ordered removal
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MAX, -32'sd1, 0, 1'b0);
        add_item(FUNC_INSERT, 32'sh7fff_ffff, 0, 1'b0);
        add_item(FUNC_INSERT, 32'sh8000_0000, 1, 1'b0);
        add_item(FUNC_INSERT, 32'sh0, 0, 1'b0);
        add_item(FUNC_INSERT, -32'sd1, 0, 1'b0);
        add_item(FUNC_UNUSED, -32'sd1, 0, 1'b0);
        add_item(FUNC_INSERT, 32'sd1, 2, 1'b0);
        add_item(FUNC_INSERT, 32'sd5, 0, 1'b0);
        add_item(FUNC_INSERT, 32'sd5, 0, 1'b0);
        add_item(FUNC_INSERT, 32'shaaaa_aaaa, 0, 1'b0);
        add_item(FUNC_INSERT, 32'sh5555_5555, 0, 1'b0);
        add_item(FUNC_UNUSED, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MAX, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MAX, 32'sh0, 3, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MAX, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MAX, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);
        add_item(FUNC_GET_MIN, 32'sh0, 0, 1'b0);

        // fill past capacity, then empty past zero
        for (int i = 0; i < CAPACITY + 4; i++)
            add_item(FUNC_INSERT, pick_value(), pick_gap(i < 40), 1'b0);
        for (int i = 0; i < CAPACITY + 3; i++)
            add_item(pick_get(), 32'sh0, pick_gap(1'b0), 1'b0);

        // random phases biased toward filling, draining or balance
        phase_no = 0;
        while (ops_queued < OP_TARGET)
        begin
            kind        = $urandom_range(0, 2);
            len         = $urandom_range(20, 120);
            quiet       = ($urandom_range(0, 3) == 0);
            drain_first = (phase_no == 3) || ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    func = FUNC_UNUSED;
                else if (r < (kind == 0 ? 80 : kind == 1 ? 25 : 52))
                    func = FUNC_INSERT;
                else
                    func = pick_get();
                add_item(func, pick_value(), pick_gap(quiet), drain_first && i == 0);
            end
            phase_no++;
        end

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // wait for all requests to transfer and all results to arrive
        while (pending_req.size() > 0 || staged || req_valid)
            @(posedge clk);
        while (awaited_rsp.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (awaited_rsp.size() > 0)
        begin
            $display("%0d expected results never arrived", awaited_rsp.size());
            mismatches++;
        end
        $display("covered %0d requests (%0d ignored codes), %0d results checked",
                 accepted_items, ignored_hits, rsp_count);
        $display("empty gets %0d, full inserts %0d, deepest queue %0d, mismatches %0d",
                 empty_hits, full_hits, max_depth, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/depq_pkg.sv
hdl/depq_cell.sv
hdl/double_ended_priority_queue.sv
bench/tb_double_ended_priority_queue.sv
